### rtl/mci_pkg.sv
// mci_pkg: shared types, codes and breakpoint tables of the meter calibration interpolator.
// No dependencies; used by mci_seg_find and meter_calibration_interpolator.
package mci_pkg;

   // meter selector codes
   localparam logic [2:0] FUNC_SIGNAL = 3'd0;
   localparam logic [2:0] FUNC_ALC    = 3'd1;
   localparam logic [2:0] FUNC_COMP   = 3'd2;
   localparam logic [2:0] FUNC_POWER  = 3'd3;
   localparam logic [2:0] FUNC_SWR    = 3'd4;
   localparam logic [2:0] FUNC_IDD    = 3'd5;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_RANGE    = 3'd1;
   localparam logic [2:0] ST_SWR_HIGH = 3'd2;
   localparam logic [2:0] ST_NOT_IMPL = 3'd3;
   localparam logic [2:0] ST_UNKNOWN  = 3'd4;

   // table rows
   localparam int NUM_METERS = 5;
   localparam int MAX_KNOTS  = 16;
   localparam logic [2:0] MTR_SIG = 3'd0;
   localparam logic [2:0] MTR_ALC = 3'd1;
   localparam logic [2:0] MTR_PWR = 3'd2;
   localparam logic [2:0] MTR_SWR = 3'd3;
   localparam logic [2:0] MTR_IDD = 3'd4;

   // datapath widths
   localparam int STEP_W    = 14;
   localparam int OFF_W     = 8;
   localparam int PROD_W    = STEP_W + OFF_W;
   localparam int RCP_SHIFT = 30;
   localparam int RCP_W     = 27;
   localparam int FULL_W    = PROD_W + RCP_W;

   localparam logic [7:0] SWR_CODE_1  = 8'(19 * 255 / 97);
   localparam logic [7:0] SWR_CODE_2  = 8'(37 * 255 / 97);
   localparam logic [7:0] SWR_CODE_3  = 8'(52 * 255 / 97);
   localparam logic [7:0] PWR_RAW_MAX = 8'd250;
   localparam logic [7:0] SWR_RAW_MAX = SWR_CODE_3;

   localparam logic [3:0] LAST_SEG [NUM_METERS] = '{4'd15, 4'd2, 4'd6, 4'd3, 4'd1};

   localparam logic [7:0] KNOT_CODE [NUM_METERS][MAX_KNOTS] = '{
      '{8'd0, 8'd12, 8'd27, 8'd40, 8'd55, 8'd65, 8'd80, 8'd95,
        8'd112, 8'd130, 8'd150, 8'd172, 8'd190, 8'd220, 8'd240, 8'd255},
      '{8'd0, 8'd157, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd0, 8'd10, 8'd50, 8'd100, 8'd150, 8'd200, 8'd250, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd0, SWR_CODE_1, SWR_CODE_2, SWR_CODE_3, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
   };

   localparam logic signed [15:0] KNOT_CENTI [NUM_METERS][MAX_KNOTS] = '{
      '{-16'sd5400, -16'sd4800, -16'sd4200, -16'sd3600,
        -16'sd3000, -16'sd2400, -16'sd1800, -16'sd1200,
        -16'sd600, 16'sd0, 16'sd1000, 16'sd2000,
        16'sd3000, 16'sd4000, 16'sd5000, 16'sd6000},
      '{16'sd0, 16'sd10000, 16'sd20000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
        16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd80, 16'sd800, 16'sd2600, 16'sd5400, 16'sd9200, 16'sd14000, 16'sd0,
        16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd100, 16'sd150, 16'sd200, 16'sd300, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
        16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd3000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
        16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}
   };

   // ceil(2^RCP_SHIFT / span) for the segment starting at each knot
   localparam int unsigned RCP_ONE = 2 ** RCP_SHIFT;
   localparam logic [RCP_W-1:0] SEG_RECIP [NUM_METERS][MAX_KNOTS] = '{
      '{RCP_W'((RCP_ONE + 11) / 12), RCP_W'((RCP_ONE + 14) / 15),
        RCP_W'((RCP_ONE + 12) / 13), RCP_W'((RCP_ONE + 14) / 15),
        RCP_W'((RCP_ONE + 9) / 10),  RCP_W'((RCP_ONE + 14) / 15),
        RCP_W'((RCP_ONE + 14) / 15), RCP_W'((RCP_ONE + 16) / 17),
        RCP_W'((RCP_ONE + 17) / 18), RCP_W'((RCP_ONE + 19) / 20),
        RCP_W'((RCP_ONE + 21) / 22), RCP_W'((RCP_ONE + 17) / 18),
        RCP_W'((RCP_ONE + 29) / 30), RCP_W'((RCP_ONE + 19) / 20),
        RCP_W'((RCP_ONE + 14) / 15), RCP_W'(0)},
      '{RCP_W'((RCP_ONE + 156) / 157), RCP_W'((RCP_ONE + 97) / 98),
        RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0),
        RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0),
        RCP_W'(0), RCP_W'(0)},
      '{RCP_W'((RCP_ONE + 9) / 10),  RCP_W'((RCP_ONE + 39) / 40),
        RCP_W'((RCP_ONE + 49) / 50), RCP_W'((RCP_ONE + 49) / 50),
        RCP_W'((RCP_ONE + 49) / 50), RCP_W'((RCP_ONE + 49) / 50),
        RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0),
        RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0)},
      '{RCP_W'((RCP_ONE + 48) / 49), RCP_W'((RCP_ONE + 47) / 48),
        RCP_W'((RCP_ONE + 38) / 39),
        RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0),
        RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0)},
      '{RCP_W'((RCP_ONE + 254) / 255),
        RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0),
        RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0),
        RCP_W'(0)}
   };

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] raw;
   } req_type;

   typedef struct packed {
      logic signed [15:0] value_centi;
      logic [3:0]         label_index;
      logic [2:0]         status;
   } rsp_type;

   // what the segment search hands to the arithmetic stages
   typedef struct packed {
      logic [2:0]         status;
      logic [3:0]         label;
      logic signed [15:0] base;
      logic [STEP_W-1:0]  step;
      logic [OFF_W-1:0]   off;
      logic [RCP_W-1:0]   recip;
   } seg_type;

   // fields that ride along unchanged to the output
   typedef struct packed {
      logic [2:0]         status;
      logic [3:0]         label;
      logic signed [15:0] base;
   } tail_type;

endpackage

### rtl/meter_calibration_interpolator.sv
// Meter calibration interpolator: four-stage pipeline. rsp_valid is the stage 4 valid register;
// an accepted request moves through the stage 1, 2, 3 and 4 registers before the response can be taken.
// Throughput one transaction per cycle; a stalled output backs up stage by stage.
// Reset clears only the stage valid bits; the payload registers are not reset.
// Depends on mci_pkg and mci_seg_find.
module meter_calibration_interpolator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mci_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mci_pkg::rsp_type rsp_data
);

   // Stage 1: segment search (tables, compares, knot select)
   // Stage 2: step * offset
   // Stage 3: product * reciprocal of segment span
   // Stage 4: shift out quotient, add lower knot value -> output register
   // Division by the span is exact: the reciprocal is rounded up and
   // product * rounding error stays below 2^RCP_SHIFT.

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

   mci_pkg::seg_type             seg_find;
   mci_pkg::seg_type             s1_seg_ff, s1_seg_in;
   mci_pkg::tail_type            s2_tail_ff, s2_tail_in;
   logic [mci_pkg::PROD_W-1:0]   s2_prod_ff, s2_prod_in;
   logic [mci_pkg::RCP_W-1:0]    s2_recip_ff, s2_recip_in;
   mci_pkg::tail_type            s3_tail_ff, s3_tail_in;
   logic [mci_pkg::FULL_W-1:0]   s3_full_ff, s3_full_in;
   logic [mci_pkg::STEP_W-1:0]   s3_quot;
   mci_pkg::rsp_type             s4_rsp_ff, s4_rsp_in;

   mci_seg_find u_seg_find (
      .req (req_data),
      .seg (seg_find)
   );

   // a stage takes new data when it is empty or its content moves on
   assign s4_rdy    = !s4_valid_ff || rsp_ready;
   assign s3_rdy    = !s3_valid_ff || s4_rdy;
   assign s2_rdy    = !s2_valid_ff || s3_rdy;
   assign s1_rdy    = !s1_valid_ff || s2_rdy;
   assign req_ready = s1_rdy;

   assign s1_valid_in = s1_rdy ? req_valid   : s1_valid_ff;
   assign s2_valid_in = s2_rdy ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_rdy ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = s4_rdy ? s3_valid_ff : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   // datapath
   always_comb begin
      s1_seg_in   = seg_find;

      s2_prod_in  = {{mci_pkg::OFF_W{1'b0}}, s1_seg_ff.step} *
                    {{mci_pkg::STEP_W{1'b0}}, s1_seg_ff.off};
      s2_recip_in = s1_seg_ff.recip;
      s2_tail_in  = '{status: s1_seg_ff.status, label: s1_seg_ff.label,
                      base: s1_seg_ff.base};

      s3_full_in  = {{mci_pkg::RCP_W{1'b0}}, s2_prod_ff} *
                    {{mci_pkg::PROD_W{1'b0}}, s2_recip_ff};
      s3_tail_in  = s2_tail_ff;

      s3_quot     = s3_full_ff[mci_pkg::RCP_SHIFT +: mci_pkg::STEP_W];
      s4_rsp_in.value_centi = s3_tail_ff.base + $signed({2'b00, s3_quot});
      s4_rsp_in.label_index = s3_tail_ff.label;
      s4_rsp_in.status      = s3_tail_ff.status;
   end

   // payload registers load only when their stage advances
   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_seg_ff <= s1_seg_in;
      end
      if (s2_rdy) begin
         s2_prod_ff  <= s2_prod_in;
         s2_recip_ff <= s2_recip_in;
         s2_tail_ff  <= s2_tail_in;
      end
      if (s3_rdy) begin
         s3_full_ff <= s3_full_in;
         s3_tail_ff <= s3_tail_in;
      end
      if (s4_rdy) begin
         s4_rsp_ff <= s4_rsp_in;
      end
   end

   assign rsp_valid = s4_valid_ff;
   assign rsp_data  = s4_rsp_ff;

   // request side only stalls when every stage holds a transaction
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && !rsp_ready))
      else $error("request stall with an empty stage");

   // errors carry no interpolation term
   a_err_prod: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && (s2_tail_ff.status != mci_pkg::ST_OK)) |-> (s2_prod_ff == '0))
      else $error("nonzero product on error transaction");

   // quotient fits the step width
   a_quot_fit: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_full_ff[mci_pkg::FULL_W-1:mci_pkg::RCP_SHIFT+mci_pkg::STEP_W] == '0))
      else $error("quotient overflow");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != mci_pkg::ST_OK)) |->
         ((rsp_data.value_centi == 16'sd0) && (rsp_data.label_index == 4'd0)))
      else $error("error response with nonzero value or label");

   // stage 3 keeps its transaction while stage 4 is blocked
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !s4_rdy) |=> s3_valid_ff)
      else $error("stage 3 transaction lost during stall");

endmodule

### rtl/mci_seg_find.sv
// mci_seg_find: meter decode, range checks and breakpoint segment search.
// Depends on mci_pkg (tables, codes, seg_type).
module mci_seg_find (
   input  mci_pkg::req_type req,
   output mci_pkg::seg_type seg
);

   logic [3:0]         cnt [mci_pkg::NUM_METERS];
   logic [2:0]         mtr;
   logic [2:0]         status;
   logic [3:0]         idx;
   logic [3:0]         idx_nx;
   logic [7:0]         code_lo;
   logic signed [15:0] centi_lo;
   logic signed [16:0] diff;
   logic               flat;

   // segment index = number of knots after the first, up to the last knot, at or below the reading
   always_comb begin
      for (int m = 0; m < mci_pkg::NUM_METERS; m++) begin
         cnt[m] = '0;
         for (int k = 1; k < mci_pkg::MAX_KNOTS; k++) begin
            if ((k <= int'(mci_pkg::LAST_SEG[m])) && (mci_pkg::KNOT_CODE[m][k] <= req.raw)) begin
               cnt[m] = cnt[m] + 4'd1;
            end
         end
      end
   end

   always_comb begin
      mtr    = mci_pkg::MTR_SIG;
      status = mci_pkg::ST_OK;
      unique case (req.func)
         mci_pkg::FUNC_SIGNAL: mtr = mci_pkg::MTR_SIG;
         mci_pkg::FUNC_ALC:    mtr = mci_pkg::MTR_ALC;
         mci_pkg::FUNC_COMP:   status = mci_pkg::ST_NOT_IMPL;
         mci_pkg::FUNC_POWER: begin
            mtr = mci_pkg::MTR_PWR;
            if (req.raw > mci_pkg::PWR_RAW_MAX) status = mci_pkg::ST_RANGE;
         end
         mci_pkg::FUNC_SWR: begin
            mtr = mci_pkg::MTR_SWR;
            if (req.raw > mci_pkg::SWR_RAW_MAX) status = mci_pkg::ST_SWR_HIGH;
         end
         mci_pkg::FUNC_IDD:    mtr = mci_pkg::MTR_IDD;
         default:              status = mci_pkg::ST_UNKNOWN;
      endcase
   end

   always_comb begin
      idx      = cnt[mtr];
      idx_nx   = idx + 4'd1;
      code_lo  = mci_pkg::KNOT_CODE[mtr][idx];
      centi_lo = mci_pkg::KNOT_CENTI[mtr][idx];
      diff     = 17'(mci_pkg::KNOT_CENTI[mtr][idx_nx]) - 17'(centi_lo);
      // exact hit, last knot or error: no interpolation term
      flat     = (req.raw == code_lo) || (idx == mci_pkg::LAST_SEG[mtr]) ||
                 (status != mci_pkg::ST_OK);

      seg.status = status;
      seg.label  = ((req.func == mci_pkg::FUNC_SIGNAL) && (status == mci_pkg::ST_OK)) ?
                   idx : 4'd0;
      seg.base   = (status == mci_pkg::ST_OK) ? centi_lo : 16'sd0;
      seg.step   = flat ? '0 : diff[mci_pkg::STEP_W-1:0];
      seg.off    = req.raw - code_lo;
      seg.recip  = mci_pkg::SEG_RECIP[mtr][idx];
   end

endmodule
